FILE: design/mscf_pkg.sv
// shared types, constants and triangle tables for the marching squares fill cell
`default_nettype none

package mscf_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SHIFT_W     = 17;
   localparam int MAG_W       = 16;
   localparam int DEN_W       = 17;
   localparam int DVS_W       = 18;
   localparam int COL_W       = 10;
   localparam int STEP_W      = 15;
   localparam int ORG_W       = 16;
   localparam int PROD_W      = 25;
   localparam int X0_W        = 27;
   localparam int VERT_W      = 28;
   localparam int OUT_W       = 16;
   localparam int NUM_VERT    = 8;
   localparam int NUM_EDGE    = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // register index codes
   localparam logic [2:0] REG_LEVEL    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [2:0] REG_STEP_X   = 3'd3;
   localparam logic [2:0] REG_STEP_Y   = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value_a;
      logic signed [SAMPLE_W-1:0] value_b;
      logic signed [SAMPLE_W-1:0] value_c;
      logic signed [SAMPLE_W-1:0] value_d;
      logic [COL_W-1:0]           cell_col;
      logic [COL_W-1:0]           cell_row;
   } req_item_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] ax;
      logic signed [OUT_W-1:0] ay;
      logic signed [OUT_W-1:0] bx;
      logic signed [OUT_W-1:0] by_coord;
      logic signed [OUT_W-1:0] cx;
      logic signed [OUT_W-1:0] cy;
      logic                    last_triangle;
   } rsp_item_type;

   // cell geometry that travels beside the dividers
   typedef struct packed {
      logic [3:0]      mask;
      logic            center;
      logic [X0_W-1:0] x0;
      logic [X0_W-1:0] y0;
   } side_type;

   // finished cell: classification plus the eight saturated vertices
   typedef struct packed {
      logic [3:0]                        mask;
      logic                              center;
      logic [NUM_VERT-1:0][OUT_W-1:0]    vx;
      logic [NUM_VERT-1:0][OUT_W-1:0]    vy;
   } cell_rec_type;

   // vertex ids: corners a b c d, then edges ab bc dc ad
   typedef logic [2:0] vid_type;
   typedef vid_type [0:2] tri_type;

   localparam logic [2:0] BASE_COUNT [16] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2};

   localparam tri_type TRI_NONE = '{3'd0, 3'd0, 3'd0};

   localparam tri_type BASE_TRI [16][4] = '{
      '{TRI_NONE, TRI_NONE, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd4, 3'd7}, TRI_NONE, TRI_NONE, TRI_NONE},
      '{'{3'd1, 3'd5, 3'd4}, TRI_NONE, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd5, 3'd7}, '{3'd0, 3'd1, 3'd5}, TRI_NONE, TRI_NONE},
      '{'{3'd2, 3'd6, 3'd5}, TRI_NONE, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd4, 3'd7}, '{3'd2, 3'd6, 3'd5}, TRI_NONE, TRI_NONE},
      '{'{3'd4, 3'd2, 3'd6}, '{3'd4, 3'd1, 3'd2}, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd1, 3'd7}, '{3'd7, 3'd1, 3'd6}, '{3'd1, 3'd2, 3'd6}, TRI_NONE},
      '{'{3'd3, 3'd7, 3'd6}, TRI_NONE, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd6, 3'd3}, '{3'd0, 3'd4, 3'd6}, TRI_NONE, TRI_NONE},
      '{'{3'd3, 3'd7, 3'd6}, '{3'd1, 3'd5, 3'd4}, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd6}, '{3'd0, 3'd6, 3'd3}, TRI_NONE},
      '{'{3'd7, 3'd2, 3'd3}, '{3'd7, 3'd5, 3'd2}, TRI_NONE, TRI_NONE},
      '{'{3'd0, 3'd4, 3'd3}, '{3'd3, 3'd4, 3'd5}, '{3'd3, 3'd5, 3'd2}, TRI_NONE},
      '{'{3'd4, 3'd1, 3'd2}, '{3'd4, 3'd2, 3'd7}, '{3'd7, 3'd2, 3'd3}, TRI_NONE},
      '{'{3'd0, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd2}, TRI_NONE, TRI_NONE}};

   localparam tri_type CENTER_TRI [2] = '{
      '{3'd4, 3'd5, 3'd6}, '{3'd4, 3'd6, 3'd7}};

   function automatic logic [2:0] tri_count(input logic [3:0] mask, input logic center);
      return BASE_COUNT[mask] + (center ? 3'd2 : 3'd0);
   endfunction

endpackage

`default_nettype wire

FILE: design/mscf_div.sv
// pipelined restoring divider lane, one quotient bit per stage
`default_nettype none

module mscf_div
   import mscf_pkg::*;
#(
   parameter int RATIO_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [RATIO_BITS+17:0]   num,
   input  wire logic [DVS_W-1:0]         dvs,
   output logic      [RATIO_BITS:0]      quo
);

   localparam int STEPS = RATIO_BITS + 1;
   localparam int NUM_W = RATIO_BITS + 18;

   logic [NUM_W-1:0] rem_ff [STEPS-1];
   logic [DVS_W-1:0] dvs_ff [STEPS-1];
   logic [STEPS-1:0] quo_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [DVS_W-1:0] dvs_prev;
      logic [STEPS-1:0] quo_prev;
      logic [NUM_W-1:0] shifted;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_prev = num;
         assign dvs_prev = dvs;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dvs_prev = dvs_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      // zero divisor never takes, so the ratio comes out zero
      assign shifted = NUM_W'(dvs_prev) << (RATIO_BITS - i);
      assign take    = (dvs_prev != '0) && (rem_prev >= shifted);

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= quo_prev | (STEPS'(take) << (RATIO_BITS - i));
         end
      end

      if (i < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= take ? rem_prev - shifted : rem_prev;
               dvs_ff[i] <= dvs_prev;
            end
         end
      end
   end

   assign quo = quo_ff[STEPS-1];

endmodule

`default_nettype wire

FILE: design/mscf_front.sv
// front pipeline: threshold, classify, crossing ratios and vertex coordinates
`default_nettype none

module mscf_front
   import mscf_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int RATIO_BITS = 12,
   parameter int INDEX_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire req_item_type         in_item,
   input  wire logic [SAMPLE_W-1:0]  level,
   input  wire logic [ORG_W-1:0]     origin_x,
   input  wire logic [ORG_W-1:0]     origin_y,
   input  wire logic [STEP_W-1:0]    step_x,
   input  wire logic [STEP_W-1:0]    step_y,
   input  wire logic                 out_full,
   output logic                      stall,
   output logic                      out_valid,
   output cell_rec_type              out_rec
);

   localparam int STEPS = RATIO_BITS + 1;
   localparam int NUM_W = RATIO_BITS + 18;
   localparam int MUL_W = STEP_W + STEPS;
   localparam int OFF_W = STEP_W + 1;
   localparam logic [COL_W-1:0] IDX_MASK =
      (INDEX_BITS >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << INDEX_BITS) - 1);
   localparam logic [MUL_W-1:0] HALF = MUL_W'(1) << (RATIO_BITS - 1);
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
   localparam int EDGE_P [NUM_EDGE] = '{0, 1, 3, 0};
   localparam int EDGE_Q [NUM_EDGE] = '{1, 2, 2, 3};

   function automatic logic [OUT_W-1:0] sat_coord(input logic signed [VERT_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > SAT_HI) begin
         w = SAT_HI;
      end else if (w < SAT_LO) begin
         w = SAT_LO;
      end
      return w[OUT_W-1:0];
   endfunction

   function automatic logic signed [VERT_W-1:0] add_off(input logic [X0_W-1:0] base,
                                                        input logic [OFF_W-1:0] off);
      return $signed({base[X0_W-1], base}) + $signed({{(VERT_W-OFF_W){1'b0}}, off});
   endfunction

   logic adv;

   // stage a: shifted corners and grid products
   logic                      a_valid_ff;
   logic [SHIFT_W-1:0]        a_sh_ff [4];
   logic [SHIFT_W-1:0]        a_sh_in [4];
   logic [PROD_W-1:0]         a_px_ff, a_py_ff;
   logic [SAMPLE_W-1:0]       sample [4];

   // stage b: divider operands and cell geometry
   logic                      b_valid_ff;
   logic [NUM_W-1:0]          b_num_ff [NUM_EDGE];
   logic [NUM_W-1:0]          b_num_in [NUM_EDGE];
   logic [DVS_W-1:0]          b_dvs_ff [NUM_EDGE];
   logic [DVS_W-1:0]          b_dvs_in [NUM_EDGE];
   side_type                  b_side_ff, b_side_in;
   logic [MAG_W-1:0]          mag [4];
   logic [DEN_W-1:0]          den [NUM_EDGE];
   logic signed [SHIFT_W+1:0] sum4;

   // divider stages
   logic                      d_valid_ff [STEPS];
   side_type                  d_side_ff [STEPS];
   logic [STEPS-1:0]          quo [NUM_EDGE];

   // stage m: offsets along the edges
   logic                      m_valid_ff;
   side_type                  m_side_ff;
   logic [OFF_W-1:0]          m_off_ff [NUM_EDGE];
   logic [OFF_W-1:0]          m_off_in [NUM_EDGE];

   // stage v: saturated vertices
   logic                      v_valid_ff;
   cell_rec_type              v_rec_ff, v_rec_in;

   assign adv   = !(v_valid_ff && out_full);
   assign stall = !adv;

   assign sample[0] = in_item.value_a;
   assign sample[1] = in_item.value_b;
   assign sample[2] = in_item.value_c;
   assign sample[3] = in_item.value_d;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_sh_in[k] = {sample[k][SAMPLE_W-1], sample[k]} - {level[SAMPLE_W-1], level};
      end
   end

   always_comb begin
      logic signed [X0_W-1:0] org_x;
      logic signed [X0_W-1:0] org_y;
      for (int k = 0; k < 4; k++) begin
         mag[k] = a_sh_ff[k][SHIFT_W-1] ? MAG_W'(-a_sh_ff[k]) : MAG_W'(a_sh_ff[k]);
      end
      sum4 = $signed({{2{a_sh_ff[0][SHIFT_W-1]}}, a_sh_ff[0]})
           + $signed({{2{a_sh_ff[1][SHIFT_W-1]}}, a_sh_ff[1]})
           + $signed({{2{a_sh_ff[2][SHIFT_W-1]}}, a_sh_ff[2]})
           + $signed({{2{a_sh_ff[3][SHIFT_W-1]}}, a_sh_ff[3]});
      for (int k = 0; k < 4; k++) begin
         b_side_in.mask[k] = !a_sh_ff[k][SHIFT_W-1] && (a_sh_ff[k] != '0);
      end
      // saddle cells fill the center when the mean of the shifted corners is above zero
      b_side_in.center = ((b_side_in.mask == 4'b0101) || (b_side_in.mask == 4'b1010))
                       && (sum4 > 0);
      org_x = $signed({{(X0_W-ORG_W){origin_x[ORG_W-1]}}, origin_x});
      org_y = $signed({{(X0_W-ORG_W){origin_y[ORG_W-1]}}, origin_y});
      b_side_in.x0 = org_x + $signed({{(X0_W-PROD_W){1'b0}}, a_px_ff});
      b_side_in.y0 = org_y + $signed({{(X0_W-PROD_W){1'b0}}, a_py_ff});
      for (int e = 0; e < NUM_EDGE; e++) begin
         den[e]      = DEN_W'(mag[EDGE_P[e]]) + DEN_W'(mag[EDGE_Q[e]]);
         b_num_in[e] = NUM_W'({mag[EDGE_P[e]], {STEPS{1'b0}}}) + NUM_W'(den[e]);
         b_dvs_in[e] = {den[e], 1'b0};
      end
   end

   for (genvar e = 0; e < NUM_EDGE; e++) begin : g_lane
      mscf_div #(.RATIO_BITS(RATIO_BITS)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (b_num_ff[e]),
         .dvs   (b_dvs_ff[e]),
         .quo   (quo[e])
      );
   end

   always_comb begin
      logic [MUL_W-1:0] prod;
      for (int e = 0; e < NUM_EDGE; e++) begin
         prod = MUL_W'((e % 2 == 0) ? step_x : step_y) * MUL_W'(quo[e]) + HALF;
         m_off_in[e] = prod[RATIO_BITS +: OFF_W];
      end
   end

   always_comb begin
      logic [OFF_W-1:0] sx;
      logic [OFF_W-1:0] sy;
      sx = {1'b0, step_x};
      sy = {1'b0, step_y};
      v_rec_in.mask   = m_side_ff.mask;
      v_rec_in.center = m_side_ff.center;
      v_rec_in.vx[0]  = sat_coord(add_off(m_side_ff.x0, '0));
      v_rec_in.vy[0]  = sat_coord(add_off(m_side_ff.y0, '0));
      v_rec_in.vx[1]  = sat_coord(add_off(m_side_ff.x0, sx));
      v_rec_in.vy[1]  = v_rec_in.vy[0];
      v_rec_in.vx[2]  = v_rec_in.vx[1];
      v_rec_in.vy[2]  = sat_coord(add_off(m_side_ff.y0, sy));
      v_rec_in.vx[3]  = v_rec_in.vx[0];
      v_rec_in.vy[3]  = v_rec_in.vy[2];
      v_rec_in.vx[4]  = sat_coord(add_off(m_side_ff.x0, m_off_ff[0]));
      v_rec_in.vy[4]  = v_rec_in.vy[0];
      v_rec_in.vx[5]  = v_rec_in.vx[1];
      v_rec_in.vy[5]  = sat_coord(add_off(m_side_ff.y0, m_off_ff[1]));
      v_rec_in.vx[6]  = sat_coord(add_off(m_side_ff.x0, m_off_ff[2]));
      v_rec_in.vy[6]  = v_rec_in.vy[2];
      v_rec_in.vx[7]  = v_rec_in.vx[0];
      v_rec_in.vy[7]  = sat_coord(add_off(m_side_ff.y0, m_off_ff[3]));
   end

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
         for (int i = 0; i < STEPS; i++) begin
            d_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         a_valid_ff    <= in_valid;
         b_valid_ff    <= a_valid_ff;
         d_valid_ff[0] <= b_valid_ff;
         for (int i = 1; i < STEPS; i++) begin
            d_valid_ff[i] <= d_valid_ff[i-1];
         end
         m_valid_ff <= d_valid_ff[STEPS-1];
         v_valid_ff <= m_valid_ff;
      end
   end

   // payload line
   always_ff @(posedge clock) begin
      if (adv) begin
         a_sh_ff  <= a_sh_in;
         a_px_ff  <= PROD_W'(in_item.cell_col & IDX_MASK) * PROD_W'(step_x);
         a_py_ff  <= PROD_W'(in_item.cell_row & IDX_MASK) * PROD_W'(step_y);
         b_num_ff <= b_num_in;
         b_dvs_ff <= b_dvs_in;
         b_side_ff <= b_side_in;
         d_side_ff[0] <= b_side_ff;
         for (int i = 1; i < STEPS; i++) begin
            d_side_ff[i] <= d_side_ff[i-1];
         end
         m_side_ff <= d_side_ff[STEPS-1];
         m_off_ff  <= m_off_in;
         v_rec_ff  <= v_rec_in;
      end
   end

   assign out_valid = v_valid_ff;
   assign out_rec   = v_rec_ff;

endmodule

`default_nettype wire

FILE: design/mscf_queue.sv
// short cell queue between the front pipeline and the triangle emitter
`default_nettype none

module mscf_queue
   import mscf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire cell_rec_type  push_rec,
   input  wire logic          pop,
   output logic               empty,
   output logic               full,
   output cell_rec_type       head
);

   cell_rec_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("cell queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("cell queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: design/mscf_emit.sv
// back end: walks the triangle list of the head cell, one triangle a cycle
`default_nettype none

module mscf_emit
   import mscf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire cell_rec_type  head,
   output logic               pop,
   output logic               rsp_valid,
   output rsp_item_type       rsp_item
);

   logic [1:0]     k_ff, k_in;
   logic [2:0]     total;
   logic           last;
   logic           emit;
   logic [1:0]     bidx;
   tri_type        tri_sel;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   assign total = tri_count(head.mask, head.center);
   assign last  = ({1'b0, k_ff} == (total - 3'd1));
   assign bidx  = head.center ? (k_ff - 2'd2) : k_ff;

   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      k_in = k_ff;
      if (head_valid) begin
         if (total == '0) begin
            pop = 1'b1;
         end else begin
            emit = 1'b1;
            if (last) begin
               pop  = 1'b1;
               k_in = '0;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
      end
   end

   // the two center triangles go first on a filled saddle
   always_comb begin
      if (head.center && !k_ff[1]) begin
         tri_sel = CENTER_TRI[k_ff[0]];
      end else begin
         tri_sel = BASE_TRI[head.mask][bidx];
      end
      rsp_item_in.ax            = head.vx[tri_sel[0]];
      rsp_item_in.ay            = head.vy[tri_sel[0]];
      rsp_item_in.bx            = head.vx[tri_sel[1]];
      rsp_item_in.by_coord      = head.vy[tri_sel[1]];
      rsp_item_in.cx            = head.vx[tri_sel[2]];
      rsp_item_in.cy            = head.vy[tri_sel[2]];
      rsp_item_in.last_triangle = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_burst_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.last_triangle |=> rsp_valid_ff)
      else $error("triangle burst of a cell broken before its last beat");
`endif

endmodule

`default_nettype wire

FILE: design/marching_squares_fill_cell_core.sv
// top level of the marching squares filled contour cell engine
// first triangle of a cell: the start beat passes stages a and b, the divider stages, stages m
//   and v, the cell queue and the emitter output register on its way to the rsp ports
// throughput: front takes one cell a cycle while not stalled; the emitter sends one triangle a
//   cycle, up to four per cell, so the front backs up once the four-entry queue fills
// busy rises only when the cell queue is full and the front pipeline is stalled
// reset: synchronous active high; clears pipeline valids, queue, emitter; presets config
`default_nettype none

module marching_squares_fill_cell_core
   import mscf_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int RATIO_BITS = 12,
   parameter int INDEX_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // cell command channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_item_type           req_item,
   // triangle result channel, one beat per triangle, no backpressure
   output logic                        rsp_valid,
   output rsp_item_type                rsp_item,
   // register port
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready
);

   // configuration registers
   logic [SAMPLE_W-1:0] level_ff;
   logic [ORG_W-1:0]    origin_x_ff;
   logic [ORG_W-1:0]    origin_y_ff;
   logic [STEP_W-1:0]   step_x_ff;
   logic [STEP_W-1:0]   step_y_ff;
   logic                csr_write;
   logic [2:0]          csr_index;

   // front to queue to emitter
   logic          accept;
   logic          front_stall;
   logic          front_valid;
   cell_rec_type  front_rec;
   logic          q_push;
   logic          q_pop;
   logic          q_empty;
   logic          q_full;
   cell_rec_type  q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         step_x_ff   <= STEP_W'(256);
         step_y_ff   <= STEP_W'(256);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LEVEL:    level_ff    <= pwdata[SAMPLE_W-1:0];
            REG_ORIGIN_X: origin_x_ff <= pwdata[ORG_W-1:0];
            REG_ORIGIN_Y: origin_y_ff <= pwdata[ORG_W-1:0];
            REG_STEP_X:   step_x_ff   <= pwdata[STEP_W-1:0];
            REG_STEP_Y:   step_y_ff   <= pwdata[STEP_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // read mux, low bits of paddr ignored
   always_comb begin
      unique case (csr_index)
         REG_LEVEL:    prdata = CSR_DATA_W'(level_ff);
         REG_ORIGIN_X: prdata = CSR_DATA_W'(origin_x_ff);
         REG_ORIGIN_Y: prdata = CSR_DATA_W'(origin_y_ff);
         REG_STEP_X:   prdata = CSR_DATA_W'(step_x_ff);
         REG_STEP_Y:   prdata = CSR_DATA_W'(step_y_ff);
         default:      prdata = '0;
      endcase
   end

   // a cell enters the front pipeline whenever it is not stalled
   assign busy   = front_stall;
   assign accept = start && !busy;

   mscf_front #(
      .COORD_BITS (COORD_BITS),
      .RATIO_BITS (RATIO_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .level     (level_ff),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .step_x    (step_x_ff),
      .step_y    (step_y_ff),
      .out_full  (q_full),
      .stall     (front_stall),
      .out_valid (front_valid),
      .out_rec   (front_rec)
   );

   // finished cell leaves the front as soon as the queue has room
   assign q_push = front_valid && !q_full;

   mscf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (front_rec),
      .pop      (q_pop),
      .empty    (q_empty),
      .full     (q_full),
      .head     (q_head)
   );

   mscf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTHESIS
   a_busy_means_backed_up: assert property (@(posedge clock) disable iff (reset)
      busy |-> (q_full && front_valid))
      else $error("command port busy while the cell queue has room");
`endif

endmodule

`default_nettype wire

FILE: test/marching_squares_fill_cell_checker.sv
// triangle predictor and scoreboard for the marching squares fill cell
`timescale 1ns / 1ps
`default_nettype none

module marching_squares_fill_cell_checker
   import mscf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire req_item_type          req_item,
   input  wire logic                  rsp_valid,
   input  wire rsp_item_type          rsp_item,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         fail_count,
   output int                         pending_tris
);

   localparam int RB = 12;

   logic signed [16:0] thr;
   logic signed [16:0] org_x, org_y;
   logic [14:0]        stp_x, stp_y;
   rsp_item_type       tri_q[$];

   assign pending_tris = tri_q.size();

   function automatic longint edge_ratio(longint vp, longint vq);
      longint np, den;
      np = vp < 0 ? -vp : vp;
      den = np + (vq < 0 ? -vq : vq);
      if (den == 0) return 0;
      return (np * (64'sd1 << (RB + 1)) + den) / (2 * den);
   endfunction

   function automatic longint edge_off(longint s, longint r);
      return (s * r + (64'sd1 << (RB - 1))) >>> RB;
   endfunction

   function automatic logic [15:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic predict_cell(input req_item_type it);
      longint v[4], vx[8], vy[8], x0, y0, sx, sy;
      logic [3:0] m;
      logic ctr;
      int total;
      tri_type t;
      rsp_item_type r;
      v[0] = longint'(it.value_a) - thr;
      v[1] = longint'(it.value_b) - thr;
      v[2] = longint'(it.value_c) - thr;
      v[3] = longint'(it.value_d) - thr;
      for (int k = 0; k < 4; k++) m[k] = v[k] > 0;
      sx = stp_x; sy = stp_y;
      x0 = org_x + longint'(it.cell_col) * sx;
      y0 = org_y + longint'(it.cell_row) * sy;
      vx[0] = x0;      vy[0] = y0;
      vx[1] = x0 + sx; vy[1] = y0;
      vx[2] = x0 + sx; vy[2] = y0 + sy;
      vx[3] = x0;      vy[3] = y0 + sy;
      vx[4] = x0 + edge_off(sx, edge_ratio(v[0], v[1])); vy[4] = y0;
      vx[5] = x0 + sx; vy[5] = y0 + edge_off(sy, edge_ratio(v[1], v[2]));
      vx[6] = x0 + edge_off(sx, edge_ratio(v[3], v[2])); vy[6] = y0 + sy;
      vx[7] = x0;      vy[7] = y0 + edge_off(sy, edge_ratio(v[0], v[3]));
      // saddles fill the center when the shifted sum is positive
      ctr = (m == 4'd5 || m == 4'd10) && (v[0] + v[1] + v[2] + v[3] > 0);
      total = BASE_COUNT[m] + (ctr ? 2 : 0);
      for (int k = 0; k < total; k++) begin
         if (ctr && k < 2) t = CENTER_TRI[k];
         else t = BASE_TRI[m][ctr ? k - 2 : k];
         r.ax = sat16(vx[t[0]]); r.ay = sat16(vy[t[0]]);
         r.bx = sat16(vx[t[1]]); r.by_coord = sat16(vy[t[1]]);
         r.cx = sat16(vx[t[2]]); r.cy = sat16(vy[t[2]]);
         r.last_triangle = (k == total - 1);
         tri_q.insert(tri_q.size(), r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         thr <= 0; org_x <= 0; org_y <= 0; stp_x <= 15'd256; stp_y <= 15'd256;
         fail_count <= 0;
         tri_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_LEVEL:    thr <= $signed(pwdata[15:0]);
               REG_ORIGIN_X: org_x <= $signed(pwdata[15:0]);
               REG_ORIGIN_Y: org_y <= $signed(pwdata[15:0]);
               REG_STEP_X:   stp_x <= pwdata[14:0];
               REG_STEP_Y:   stp_y <= pwdata[14:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (tri_q.size() == 0) begin
               $display("%0t: unexpected triangle beat, expected none, actual %p", $time,
                  rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               if (tri_q[0] !== rsp_item) begin
                  $display("%0t: triangle mismatch, expected %p, actual %p", $time,
                     tri_q[0], rsp_item);
                  fail_count <= fail_count + 1;
               end
               void'(tri_q.pop_front());
            end
         end
         if (start && !busy) predict_cell(req_item);
      end
   end

endmodule

`default_nettype wire

FILE: test/marching_squares_fill_cell_core_tb.sv
// stimulus and verdict for the marching squares fill cell core
`timescale 1ns / 1ps
`default_nettype none

module marching_squares_fill_cell_core_tb;
   import mscf_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   rsp_item_type          rsp_item;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count, pending_tris;
   int                    idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   marching_squares_fill_cell_core u_dut (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

   marching_squares_fill_cell_checker u_chk (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending_tris);

   // watchdog: a stretch with no beat of any kind ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("marching_squares_fill_cell_core verification failed");
         $finish;
      end
   end

   // setup then access cycle, driven on falling edges
   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = CSR_ADDR_W'({idx, 2'b00}); pwdata = {16'h0, val};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // hold a cell beat until it is taken; start stays high for back-to-back beats
   task automatic send_cell(input req_item_type it, input bit keep);
      req_item = it;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (!keep) start = 1'b0;
   endtask

   // wait for every expected triangle, then let the pipeline empty
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_tris != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_sample(int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_item_type rand_cell(int mode);
      req_item_type c;
      c.value_a = rand_sample(mode == 3 ? int'($urandom_range(0, 3)) : mode);
      c.value_b = rand_sample(mode == 3 ? int'($urandom_range(0, 3)) : mode);
      c.value_c = rand_sample(mode == 3 ? int'($urandom_range(0, 3)) : mode);
      c.value_d = rand_sample(mode == 3 ? int'($urandom_range(0, 3)) : mode);
      c.cell_col = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 8));
      c.cell_row = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 8));
      return c;
   endfunction

   task automatic random_phase(input int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_cell(rand_cell(int'($urandom_range(2, 3))), k < burst - 1);
            sent++;
         end
         start = 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   initial begin
      req_item_type c;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every corner mask, extremes and saddles at the reset setting
      for (int m = 0; m < 16; m++) begin
         c.value_a = m[0] ? 16'sd100 : -16'sd60;
         c.value_b = m[1] ? 16'sd40  : -16'sd90;
         c.value_c = m[2] ? 16'sd70  : -16'sd10;
         c.value_d = m[3] ? 16'sd20  : -16'sd30;
         c.cell_col = 10'(m); c.cell_row = 10'(15 - m);
         send_cell(c, 1'b1);
      end
      // saddles with the center empty
      c = '{16'sd5, -16'sd90, 16'sd5, -16'sd90, 10'd1, 10'd1}; send_cell(c, 1'b1);
      c = '{-16'sd90, 16'sd5, -16'sd90, 16'sd5, 10'd2, 10'd1}; send_cell(c, 1'b1);
      // corners exactly at the level are not above
      c = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 10'd0, 10'd0}; send_cell(c, 1'b1);
      // full-scale samples and top indices for saturation
      c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 10'h3ff, 10'h3ff}; send_cell(c, 1'b1);
      c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 10'h3ff, 10'h000}; send_cell(c, 1'b1);
      c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 10'h000, 10'h3ff}; send_cell(c, 1'b0);
      drain();

      random_phase(120);
      drain();

      // extreme setting: low level, negative x origin and positive y origin, widest x step, narrowest y step
      csr_write(REG_LEVEL, 16'h8000);
      csr_write(REG_ORIGIN_X, 16'h8000);
      csr_write(REG_ORIGIN_Y, 16'h7fff);
      csr_write(REG_STEP_X, 16'h7fff);
      csr_write(REG_STEP_Y, 16'h0001);
      random_phase(80);
      drain();

      // high level: first cells with every corner above, then random cells with few above
      csr_write(REG_LEVEL, 16'h7ffe);
      csr_write(REG_ORIGIN_X, 16'h7fff);
      csr_write(REG_ORIGIN_Y, 16'h8000);
      csr_write(REG_STEP_X, 16'h0001);
      csr_write(REG_STEP_Y, 16'h7fff);
      for (int k = 0; k < 40; k++) send_cell(rand_cell(1), 1'b0);
      random_phase(40);
      drain();

      // zero steps collapse the cell; random mid settings after that
      csr_write(REG_STEP_X, 16'h0000);
      csr_write(REG_STEP_Y, 16'h0000);
      random_phase(40);
      drain();
      for (int p = 0; p < 4; p++) begin
         csr_write(REG_LEVEL, 16'($urandom_range(0, 40) - 20));
         csr_write(REG_ORIGIN_X, 16'($urandom));
         csr_write(REG_ORIGIN_Y, 16'($urandom));
         csr_write(REG_STEP_X, 16'($urandom_range(1, 600)));
         csr_write(REG_STEP_Y, 16'($urandom_range(1, 600)));
         random_phase(45);
         drain();
      end

      if (fail_count == 0) $display("marching_squares_fill_cell_core verification clean");
      else $display("marching_squares_fill_cell_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire
